>>> sv/sawa_pkg.sv
package sawa_pkg;

  // Field and state widths
  localparam int SEG_BYTES = 1024;
  localparam int LEN_BITS  = 16;
  localparam int SEG_LEN_W = $clog2(SEG_BYTES + 1);
  localparam int SEQ_W     = 32;
  localparam int TMO_W     = 32;
  localparam int BASE_W    = 24;
  localparam int RETRY_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(10000);
  localparam logic [RETRY_W-1:0] RETRY_RESET = RETRY_W'(10);

  localparam logic [SEG_LEN_W-1:0] SEG_MAX = SEG_LEN_W'(SEG_BYTES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 1'b1;

  typedef enum logic [2:0] {
    REQ_START_WRITE = 3'd0,
    REQ_START_READ  = 3'd1,
    REQ_ACK         = 3'd2,
    REQ_SEGMENT     = 3'd3,
    REQ_TICK        = 3'd4
  } req_type_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [LEN_BITS-1:0] length;
    logic [SEQ_W-1:0]    seq;
  } in_item_t;

  typedef struct packed {
    logic                 send_segment;
    logic [SEQ_W-1:0]     seg_seq;
    logic [LEN_BITS-1:0]  seg_offset;
    logic [SEG_LEN_W-1:0] seg_len;
    logic                 write_done;
    logic                 failed;
  } tx_result_t;

  typedef struct packed {
    logic                 send_ack;
    logic [SEQ_W-1:0]     ack_seq;
    logic [SEG_LEN_W-1:0] deliver_len;
    logic [LEN_BITS-1:0]  deliver_offset;
    logic                 from_overflow;
    logic                 read_done;
  } rx_result_t;

  // Clamp a byte count to one segment
  function automatic logic [SEG_LEN_W-1:0] clamp_seg(input logic [LEN_BITS-1:0] n);
    if (n > LEN_BITS'(SEG_BYTES)) begin
      return SEG_MAX;
    end
    return n[SEG_LEN_W-1:0];
  endfunction

endpackage

>>> sv/sawa_tx.sv
module sawa_tx import sawa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 fire,
  input  in_item_t             item,
  output logic                 failed_flag,
  output tx_result_t           res
);

  logic [BASE_W-1:0]   base_timeout;
  logic [RETRY_W-1:0]  max_retries;
  logic [SEQ_W-1:0]    local_seq, local_seq_next;
  logic [LEN_BITS-1:0] write_total, write_total_next;
  logic [LEN_BITS-1:0] write_progress, write_progress_next;
  logic                write_active, write_active_next;
  logic [RETRY_W-1:0]  retry_count, retry_count_next;
  logic [TMO_W-1:0]    current_timeout, current_timeout_next;
  logic [TMO_W-1:0]    timer_remaining, timer_remaining_next;
  logic                timer_armed, timer_armed_next;
  logic                failed_flag_next;

  logic [TMO_W-1:0]    eff_base;
  logic [LEN_BITS:0]   prog_sum;
  logic [LEN_BITS-1:0] prog_adv;
  logic [TMO_W-1:0]    tick_dec;
  logic [TMO_W:0]      grown_wide;
  logic [TMO_W-1:0]    grown;

  assign eff_base   = (base_timeout == '0) ? TMO_W'(1) : TMO_W'(base_timeout);
  assign prog_sum   = {1'b0, write_progress} + (LEN_BITS + 1)'(SEG_BYTES);
  assign prog_adv   = (prog_sum > {1'b0, write_total}) ? write_total
                                                       : prog_sum[LEN_BITS-1:0];
  assign tick_dec   = (timer_remaining == '0) ? '0 : timer_remaining - TMO_W'(1);
  assign grown_wide = {1'b0, current_timeout} + {2'b0, current_timeout[TMO_W-1:1]};
  assign grown      = grown_wide[TMO_W] ? '1 : grown_wide[TMO_W-1:0];

  always_comb begin
    local_seq_next       = local_seq;
    write_total_next     = write_total;
    write_progress_next  = write_progress;
    write_active_next    = write_active;
    retry_count_next     = retry_count;
    current_timeout_next = current_timeout;
    timer_remaining_next = timer_remaining;
    timer_armed_next     = timer_armed;
    failed_flag_next     = failed_flag;
    res                  = '0;
    if (fire && !failed_flag) begin
      unique case (item.req_type)
        REQ_START_WRITE: begin
          write_total_next     = item.length;
          write_progress_next  = '0;
          write_active_next    = 1'b1;
          retry_count_next     = '0;
          current_timeout_next = eff_base;
          timer_remaining_next = eff_base;
          timer_armed_next     = 1'b1;
          res.send_segment     = 1'b1;
          res.seg_seq          = local_seq;
          res.seg_len          = clamp_seg(item.length);
        end
        REQ_ACK: begin
          if (write_active && item.seq == local_seq) begin
            local_seq_next       = local_seq + SEQ_W'(1);
            retry_count_next     = '0;
            current_timeout_next = eff_base;
            write_progress_next  = prog_adv;
            if (prog_adv == write_total) begin
              write_active_next    = 1'b0;
              timer_armed_next     = 1'b0;
              timer_remaining_next = '0;
              res.write_done       = 1'b1;
            end else begin
              timer_armed_next     = 1'b1;
              timer_remaining_next = eff_base;
              res.send_segment     = 1'b1;
              res.seg_seq          = local_seq + SEQ_W'(1);
              res.seg_offset       = prog_adv;
              res.seg_len          = clamp_seg(write_total - prog_adv);
            end
          end
        end
        REQ_TICK: begin
          if (timer_armed) begin
            timer_remaining_next = tick_dec;
            if (tick_dec == '0) begin
              timer_armed_next = 1'b0;
              if (retry_count >= max_retries) begin
                failed_flag_next  = 1'b1;
                write_active_next = 1'b0;
              end else begin
                retry_count_next     = retry_count + RETRY_W'(1);
                current_timeout_next = grown;
                if (write_active) begin
                  // resend the pending segment with the grown timeout
                  timer_remaining_next = grown;
                  timer_armed_next     = 1'b1;
                  res.send_segment     = 1'b1;
                  res.seg_seq          = local_seq;
                  res.seg_offset       = write_progress;
                  res.seg_len          = clamp_seg(write_total - write_progress);
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.failed = failed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_timeout    <= BASE_RESET;
      max_retries     <= RETRY_RESET;
      local_seq       <= '0;
      write_total     <= '0;
      write_progress  <= '0;
      write_active    <= 1'b0;
      retry_count     <= '0;
      current_timeout <= TMO_W'(BASE_RESET);
      timer_remaining <= '0;
      timer_armed     <= 1'b0;
      failed_flag     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_TIMEOUT: base_timeout <= cfg_data;
          CFG_MAX_RETRIES:  max_retries  <= cfg_data[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
      local_seq       <= local_seq_next;
      write_total     <= write_total_next;
      write_progress  <= write_progress_next;
      write_active    <= write_active_next;
      retry_count     <= retry_count_next;
      current_timeout <= current_timeout_next;
      timer_remaining <= timer_remaining_next;
      timer_armed     <= timer_armed_next;
      failed_flag     <= failed_flag_next;
    end
  end

  a_armed_needs_write: assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> write_active)
    else $error("retransmit timer armed with no write in progress");

  a_progress_bound: assert property (@(posedge clk) disable iff (rst)
    write_progress <= write_total)
    else $error("write progress beyond write total");

endmodule

>>> sv/sawa_rx.sv
module sawa_rx import sawa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       failed_flag,
  input  in_item_t   item,
  output rx_result_t res
);

  logic [SEQ_W-1:0]     peer_seq, peer_seq_next;
  logic [LEN_BITS-1:0]  read_total, read_total_next;
  logic [LEN_BITS-1:0]  read_progress, read_progress_next;
  logic                 read_active, read_active_next;
  logic [SEG_LEN_W-1:0] overflow_len, overflow_len_next;

  logic [SEG_LEN_W-1:0] drain_n;
  logic [SEG_LEN_W-1:0] slen;
  logic [LEN_BITS-1:0]  room;
  logic [SEG_LEN_W-1:0] take_n;
  logic [SEQ_W-1:0]     seq_diff;

  assign drain_n = (LEN_BITS'(overflow_len) < item.length) ? overflow_len
                                                            : item.length[SEG_LEN_W-1:0];
  assign slen    = clamp_seg(item.length);
  assign room    = read_total - read_progress;
  assign take_n  = (LEN_BITS'(slen) < room) ? slen : room[SEG_LEN_W-1:0];

  always_comb begin
    peer_seq_next      = peer_seq;
    read_total_next    = read_total;
    read_progress_next = read_progress;
    read_active_next   = read_active;
    overflow_len_next  = overflow_len;
    res                = '0;
    seq_diff           = '0;
    if (fire && !failed_flag) begin
      unique case (item.req_type)
        REQ_START_READ: begin
          read_total_next    = item.length;
          read_progress_next = '0;
          read_active_next   = 1'b1;
          // drain held overflow into the new read first
          if (overflow_len != '0) begin
            read_progress_next = LEN_BITS'(drain_n);
            overflow_len_next  = overflow_len - drain_n;
            if (drain_n != '0) begin
              res.deliver_len   = drain_n;
              res.from_overflow = 1'b1;
            end
          end
          if (read_progress_next == item.length) begin
            read_active_next = 1'b0;
            res.read_done    = 1'b1;
          end
        end
        REQ_SEGMENT: begin
          if (read_active) begin
            if (item.seq == peer_seq + SEQ_W'(1) && overflow_len == '0) begin
              if (take_n != '0) begin
                res.deliver_len    = take_n;
                res.deliver_offset = read_progress;
              end
              read_progress_next = read_progress + LEN_BITS'(take_n);
              if (take_n != slen) begin
                overflow_len_next = slen - take_n;
              end
              peer_seq_next = item.seq;
            end
            if (read_progress_next == read_total) begin
              read_active_next = 1'b0;
              res.read_done    = 1'b1;
            end
          end
          // ack anything not ahead of the last in-order segment
          seq_diff = item.seq - peer_seq_next;
          if (seq_diff == '0 || seq_diff[SEQ_W-1]) begin
            res.send_ack = 1'b1;
            res.ack_seq  = peer_seq_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_seq      <= '0;
      read_total    <= '0;
      read_progress <= '0;
      read_active   <= 1'b0;
      overflow_len  <= '0;
    end else begin
      peer_seq      <= peer_seq_next;
      read_total    <= read_total_next;
      read_progress <= read_progress_next;
      read_active   <= read_active_next;
      overflow_len  <= overflow_len_next;
    end
  end

  a_overflow_idle: assert property (@(posedge clk) disable iff (rst)
    (overflow_len != '0) |-> !read_active)
    else $error("overflow held while a read is still open");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    read_progress <= read_total)
    else $error("read progress beyond read total");

endmodule

>>> sv/stop_and_wait_arq_endpoint.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: length, seq
// m_*       out  m_tvalid/m_tready  tuser: flags; tdata: segment, ack, delivery, status
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_data its value
//
// Throughput is one item per cycle unless m_tready stalls the result; an item
// passes through the input register and then the result register, with the
// protocol state updated as the item moves from the first to the second.
// Reset (rst, synchronous) empties both registers and clears the protocol state.
// A stall on m_tready holds the result; the input register still takes an item
// while it is empty, or while the result register is free or being drained in the same cycle.
module stop_and_wait_arq_endpoint import sawa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // length[15:0], seq[47:16]
  input  logic [2:0]           s_tuser,   // req_type[2:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata,   // seg_seq[31:0], seg_offset[47:32],
                                          // seg_len[58:48], ack_seq[90:59],
                                          // deliver_len[101:91],
                                          // deliver_offset[117:102],
                                          // write_done[118], read_done[119],
                                          // failed[120], zero fill above
  output logic [2:0]           m_tuser,   // send_segment[0], send_ack[1],
                                          // from_overflow[2]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data
);

  logic       in_valid;
  in_item_t   in_item;
  logic       out_free;
  logic       fire;
  logic       failed_flag;
  tx_result_t tx_res;
  rx_result_t rx_res;
  tx_result_t tx_out;
  rx_result_t rx_out;

  // Advance the held item whenever the result register can take it
  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // Capture the payload of an accepted item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type <= req_type_t'(s_tuser);
      in_item.length   <= s_tdata[15:0];
      in_item.seq      <= s_tdata[47:16];
    end
  end

  sawa_tx u_tx (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fire        (fire),
    .item        (in_item),
    .failed_flag (failed_flag),
    .res         (tx_res)
  );

  sawa_rx u_rx (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .failed_flag (failed_flag),
    .item        (in_item),
    .res         (rx_res)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_out <= tx_res;
      rx_out <= rx_res;
    end
  end

  assign m_tuser = {rx_out.from_overflow, rx_out.send_ack, tx_out.send_segment};
  assign m_tdata = {7'd0,
                    tx_out.failed,
                    rx_out.read_done,
                    tx_out.write_done,
                    rx_out.deliver_offset,
                    rx_out.deliver_len,
                    rx_out.ack_seq,
                    tx_out.seg_len,
                    tx_out.seg_offset,
                    tx_out.seg_seq};

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    (fire && failed_flag) |=> (m_tvalid && m_tdata[120] && m_tuser == 3'd0))
    else $error("item after failure did not report failed alone");

endmodule

>>> bench/arq_endpoint_checker.sv
module arq_endpoint_checker import sawa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [47:0]          s_tdata,   // length[15:0], seq[47:16]
  input  logic [2:0]           s_tuser,   // req_type[2:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [127:0]         m_tdata,   // seg_seq, seg_offset, seg_len, ack_seq,
                                          // deliver_len, deliver_offset,
                                          // write_done, read_done, failed
  input  logic [2:0]           m_tuser,   // send_segment, send_ack, from_overflow
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  output int                   errors,
  output int                   outstanding
);

  typedef struct {
    logic                 send_segment;
    logic [SEQ_W-1:0]     seg_seq;
    logic [LEN_BITS-1:0]  seg_offset;
    logic [SEG_LEN_W-1:0] seg_len;
    logic                 send_ack;
    logic [SEQ_W-1:0]     ack_seq;
    logic [SEG_LEN_W-1:0] deliver_len;
    logic [LEN_BITS-1:0]  deliver_offset;
    logic                 from_overflow;
    logic                 write_done;
    logic                 read_done;
    logic                 failed;
  } arq_result_t;

  arq_result_t expected_results[$];
  int fail_count = 0;
  int waiting = 0;

  assign errors      = fail_count;
  assign outstanding = waiting;

  // Endpoint state mirror
  logic [BASE_W-1:0]   base_tmo;
  logic [RETRY_W-1:0]  retry_limit;
  logic [SEQ_W-1:0]    tx_seq, rx_seq;
  logic [LEN_BITS-1:0] wr_total, wr_sent, rd_total, rd_filled;
  logic                wr_busy, rd_busy, rto_armed, dead;
  logic [SEG_LEN_W-1:0] held_len;
  logic [RETRY_W-1:0]  retries;
  logic [TMO_W-1:0]    rto, rto_left;

  function automatic logic [TMO_W-1:0] reload_timeout();
    return (base_tmo == '0) ? TMO_W'(1) : TMO_W'(base_tmo);
  endfunction

  function automatic void issue_segment(inout arq_result_t r);
    logic [LEN_BITS-1:0] remain;
    remain         = wr_total - wr_sent;
    r.send_segment = 1'b1;
    r.seg_seq      = tx_seq;
    r.seg_offset   = wr_sent;
    r.seg_len      = (remain > LEN_BITS'(SEG_BYTES)) ? SEG_MAX : remain[SEG_LEN_W-1:0];
    rto_left       = rto;
    rto_armed      = 1'b1;
  endfunction

  function automatic arq_result_t advance_endpoint(input logic [2:0] req,
                                                   input logic [LEN_BITS-1:0] len,
                                                   input logic [SEQ_W-1:0] seq);
    arq_result_t r;
    logic [LEN_BITS:0]    next_sent;
    logic [LEN_BITS-1:0]  take, room, slen;
    logic [TMO_W:0]       grown;
    logic [SEQ_W-1:0]     gap;
    r = '{default: '0};
    if (!dead) begin
      case (req)
        REQ_START_WRITE: begin
          wr_total = len;
          wr_sent  = '0;
          wr_busy  = 1'b1;
          retries  = '0;
          rto      = reload_timeout();
          issue_segment(r);
        end
        REQ_START_READ: begin
          rd_total  = len;
          rd_filled = '0;
          rd_busy   = 1'b1;
          if (held_len != '0) begin
            take = (LEN_BITS'(held_len) < len) ? LEN_BITS'(held_len) : len;
            if (take != '0) begin
              r.deliver_len   = take[SEG_LEN_W-1:0];
              r.from_overflow = 1'b1;
            end
            rd_filled = take;
            held_len  = held_len - take[SEG_LEN_W-1:0];
          end
          if (rd_filled == rd_total) begin
            rd_busy     = 1'b0;
            r.read_done = 1'b1;
          end
        end
        REQ_ACK: begin
          if (wr_busy && seq == tx_seq) begin
            rto_armed = 1'b0;
            rto_left  = '0;
            tx_seq    = tx_seq + SEQ_W'(1);
            retries   = '0;
            rto       = reload_timeout();
            next_sent = {1'b0, wr_sent} + (LEN_BITS+1)'(SEG_BYTES);
            wr_sent   = (next_sent > {1'b0, wr_total}) ? wr_total : next_sent[LEN_BITS-1:0];
            if (wr_sent == wr_total) begin
              wr_busy      = 1'b0;
              r.write_done = 1'b1;
            end else begin
              issue_segment(r);
            end
          end
        end
        REQ_SEGMENT: begin
          slen = (len > LEN_BITS'(SEG_BYTES)) ? LEN_BITS'(SEG_BYTES) : len;
          if (rd_busy) begin
            if (seq == rx_seq + SEQ_W'(1) && held_len == '0) begin
              room = rd_total - rd_filled;
              take = (slen < room) ? slen : room;
              if (take != '0) begin
                r.deliver_len    = take[SEG_LEN_W-1:0];
                r.deliver_offset = rd_filled;
              end
              rd_filled = rd_filled + take;
              if (take != slen) held_len = SEG_LEN_W'(slen - take);
              rx_seq = seq;
            end
            if (rd_filled == rd_total) begin
              rd_busy     = 1'b0;
              r.read_done = 1'b1;
            end
          end
          // ack anything at or behind the last in-order number, serial order
          gap = seq - rx_seq;
          if (gap == '0 || gap[SEQ_W-1]) begin
            r.send_ack = 1'b1;
            r.ack_seq  = rx_seq;
          end
        end
        REQ_TICK: begin
          if (rto_armed) begin
            if (rto_left != '0) rto_left = rto_left - TMO_W'(1);
            if (rto_left == '0) begin
              rto_armed = 1'b0;
              if (retries >= retry_limit) begin
                dead    = 1'b1;
                wr_busy = 1'b0;
              end else begin
                grown   = {1'b0, rto} + {2'b0, rto[TMO_W-1:1]};
                retries = retries + RETRY_W'(1);
                rto     = grown[TMO_W] ? '1 : grown[TMO_W-1:0];
                if (wr_busy) issue_segment(r);
              end
            end
          end
        end
        default: ;
      endcase
    end
    r.failed = dead;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    arq_result_t want;
    if (rst) begin
      base_tmo    = BASE_RESET;
      retry_limit = RETRY_RESET;
      tx_seq      = '0;
      rx_seq      = '0;
      wr_total    = '0;
      wr_sent     = '0;
      wr_busy     = 1'b0;
      rd_total    = '0;
      rd_filled   = '0;
      rd_busy     = 1'b0;
      held_len    = '0;
      retries     = '0;
      rto         = reload_timeout();
      rto_left    = '0;
      rto_armed   = 1'b0;
      dead        = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_TIMEOUT) base_tmo = cfg_data;
        else if (cfg_index == CFG_MAX_RETRIES) retry_limit = cfg_data[RETRY_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("send_segment",   want.send_segment,   m_tuser[0]);
          check_field("seg_seq",        want.seg_seq,        m_tdata[31:0]);
          check_field("seg_offset",     want.seg_offset,     m_tdata[47:32]);
          check_field("seg_len",        want.seg_len,        m_tdata[58:48]);
          check_field("send_ack",       want.send_ack,       m_tuser[1]);
          check_field("ack_seq",        want.ack_seq,        m_tdata[90:59]);
          check_field("deliver_len",    want.deliver_len,    m_tdata[101:91]);
          check_field("deliver_offset", want.deliver_offset, m_tdata[117:102]);
          check_field("from_overflow",  want.from_overflow,  m_tuser[2]);
          check_field("write_done",     want.write_done,     m_tdata[118]);
          check_field("read_done",      want.read_done,      m_tdata[119]);
          check_field("failed",         want.failed,         m_tdata[120]);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(advance_endpoint(s_tuser, s_tdata[15:0], s_tdata[47:16]));
    end
    waiting = expected_results.size();
  end

endmodule

>>> bench/tb_stop_and_wait_arq_endpoint.sv
module tb_stop_and_wait_arq_endpoint;
  import sawa_pkg::*;

  // Codes past the last defined request; the block must ignore them
  localparam logic [2:0] REQ_CODE_TOP = 3'b111;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;   // length[15:0], seq[47:16]
  logic [2:0]           s_tuser = '0;   // req_type[2:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [127:0]         m_tdata;        // seg_seq .. failed, see block ports
  logic [2:0]           m_tuser;        // send_segment, send_ack, from_overflow
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BASE_W-1:0]    cfg_data = '0;

  int  errors;
  int  outstanding;
  bit  quiet = 1'b0;   // no idling on either side once set
  int  sent = 0;

  // Light view of the protocol so that the stimulus can build acks and
  // in-order segments, and keep the retry timer away from its limit
  logic [31:0] wr_next_seq = '0;
  int          wr_segs_left = 0;
  bit          wr_open = 1'b0;
  int          ticks_unacked = 0;
  int          retry_cap = 10;
  logic [31:0] rd_last_seq = '0;
  int          rd_left = 0;
  int          rd_held = 0;
  bit          rd_open = 1'b0;

  always #2 clk = ~clk;

  stop_and_wait_arq_endpoint i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  arq_endpoint_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Mostly ordinary sizes, with the extremes mixed in
  function automatic logic [15:0] rand_len(input int typical);
    case ($urandom_range(0, 19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      4, 5, 6: return 16'($urandom_range(0, 16));
      default: return 16'($urandom_range(0, typical));
    endcase
  endfunction

  // Track the item's effect on sequence numbers, then offer it until taken.
  // Called and returns at a falling edge.
  task automatic issue(input logic [2:0] req, input logic [15:0] len,
                       input logic [31:0] seq);
    int take;
    int slen;
    bit calm;
    case (req)
      REQ_START_WRITE: begin
        wr_open       = 1'b1;
        wr_segs_left  = (len == 0) ? 1 : (int'(len) + SEG_BYTES - 1) / SEG_BYTES;
        ticks_unacked = 0;
      end
      REQ_START_READ: begin
        take    = (rd_held < int'(len)) ? rd_held : int'(len);
        rd_held = rd_held - take;
        rd_left = int'(len) - take;
        rd_open = (rd_left != 0);
      end
      REQ_ACK: begin
        if (wr_open && seq == wr_next_seq) begin
          wr_next_seq   = wr_next_seq + 32'd1;
          wr_segs_left  = wr_segs_left - 1;
          ticks_unacked = 0;
          if (wr_segs_left == 0) wr_open = 1'b0;
        end
      end
      REQ_SEGMENT: begin
        if (rd_open && seq == rd_last_seq + 32'd1 && rd_held == 0) begin
          slen        = (int'(len) > SEG_BYTES) ? SEG_BYTES : int'(len);
          take        = (slen < rd_left) ? slen : rd_left;
          rd_left     = rd_left - take;
          rd_held     = slen - take;
          rd_last_seq = seq;
          rd_open     = (rd_left != 0);
        end
      end
      REQ_TICK: begin
        if (wr_open) ticks_unacked++;
      end
      default: ;
    endcase
    // Alternate busy and calm stretches on the sender side
    calm = ((sent / 40) % 3 == 0);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {seq, len};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  // Drop valid, wait for every expected result, then cover the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic reconfigure(input logic [BASE_W-1:0] base, input logic [RETRY_W-1:0] cap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_TIMEOUT;
    cfg_data  <= base;
    @(negedge clk);
    cfg_index <= CFG_MAX_RETRIES;
    cfg_data  <= BASE_W'(cap);
    @(negedge clk);
    cfg_we    <= 1'b0;
    retry_cap = cap;
  endtask

  task automatic rand_item(output bit counted);
    int          pick;
    logic [2:0]  req;
    logic [15:0] len;
    logic [31:0] seq;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    len     = 16'($urandom);
    seq     = $urandom;
    if (pick < 6) begin
      req = REQ_START_WRITE;
      len = rand_len(3000);
    end else if (pick < 12) begin
      req = REQ_START_READ;
      len = rand_len(3000);
    end else if (pick < 40) begin
      req = REQ_ACK;
      case ($urandom_range(0, 19))
        0:       seq = $urandom;
        1:       seq = wr_next_seq - 32'd1;
        2:       seq = wr_next_seq + 32'($urandom_range(1, 3));
        default: seq = wr_next_seq;
      endcase
    end else if (pick < 72) begin
      req = REQ_SEGMENT;
      len = rand_len(SEG_BYTES);
      case ($urandom_range(0, 19))
        0, 1:    seq = $urandom;
        2:       seq = rd_last_seq;
        3:       seq = rd_last_seq - 32'($urandom_range(1, 100));
        default: seq = rd_last_seq + 32'd1;
      endcase
    end else if (pick < 96) begin
      // Hold the expiry count below the limit: ack instead of another tick
      if (wr_open && ticks_unacked >= retry_cap) begin
        req = REQ_ACK;
        seq = wr_next_seq;
      end else begin
        req = REQ_TICK;
      end
    end else begin
      req     = 3'(REQ_TICK) + 3'($urandom_range(1, 3));
      counted = 1'b0;
    end
    issue(req, len, seq);
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] base, input logic [RETRY_W-1:0] cap,
                           input int count);
    int done_items;
    bit counted;
    reconfigure(base, cap);
    // Reload the retry state under the new limit before any tick
    issue(REQ_START_WRITE, rand_len(3000), $urandom);
    done_items = 0;
    while (done_items < count) begin
      rand_item(counted);
      if (counted) done_items++;
    end
  endtask

  // Result side: short stalls, long open stretches, and one long hold-off
  // that fills the block and backs up the sender
  initial begin : result_sink
    int span;
    int cyc;
    bit held_off;
    cyc      = 0;
    held_off = 1'b0;
    @(negedge clk);
    forever begin
      if (quiet) begin
        m_tready <= 1'b1;
        span = 1;
      end else if (!held_off && cyc >= 1500) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        span = 150;
      end else if ($urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        span = $urandom_range(1, 6);
      end else begin
        m_tready <= 1'b1;
        span = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      end
      repeat (span) @(negedge clk);
      cyc += span;
    end
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL stop_and_wait_arq_endpoint");
    $finish;
  end

  initial begin : stimulus
    int k;
    bit counted;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset configuration
    issue(REQ_START_READ, 16'd0, 32'd0);              // empty read, done at once
    issue(REQ_TICK, 16'd0, 32'd0);                    // no timer armed
    issue(REQ_TICK + 3'd1, 16'hFFFF, 32'hFFFF_FFFF);  // undefined request
    issue(REQ_ACK, 16'd0, 32'd0);                     // ack with no write open
    issue(REQ_START_WRITE, 16'd0, 32'd0);             // one empty segment
    issue(REQ_ACK, 16'd0, wr_next_seq);               // completes it
    issue(REQ_START_WRITE, 16'hFFFF, 32'd0);
    issue(REQ_ACK, 16'd0, 32'hFFFF_FFFF);             // wrong number
    issue(REQ_ACK, 16'd0, wr_next_seq);
    issue(REQ_START_WRITE, 16'd1500, 32'd0);          // restart mid-transfer
    issue(REQ_ACK, 16'd0, wr_next_seq);
    issue(REQ_ACK, 16'd0, wr_next_seq);
    issue(REQ_SEGMENT, 16'd5, 32'd0);                 // no read open, still acked
    issue(REQ_SEGMENT, 16'd5, 32'd1);                 // ahead, not acked
    issue(REQ_START_READ, 16'd100, 32'd0);
    issue(REQ_SEGMENT, 16'hFFFF, rd_last_seq + 32'd1); // oversized, leaves overflow
    issue(REQ_SEGMENT, 16'd10, rd_last_seq + 32'd1);  // refused while overflow held
    issue(REQ_SEGMENT, 16'd10, rd_last_seq - 32'd5);  // old number, acked
    issue(REQ_START_READ, 16'd500, 32'd0);            // served from overflow alone
    issue(REQ_START_READ, 16'd1000, 32'd0);           // drains the rest, stays open
    issue(REQ_SEGMENT, 16'd1024, rd_last_seq + 32'd1);
    issue(REQ_CODE_TOP, 16'd0, 32'd0);

    // Zero base timeout behaves as one tick; retries stay at one tick each
    reconfigure('0, 5'd3);
    issue(REQ_START_WRITE, 16'd2000, 32'd0);
    issue(REQ_TICK, 16'd0, 32'd0);
    issue(REQ_TICK, 16'd0, 32'd0);
    issue(REQ_ACK, 16'd0, wr_next_seq);
    issue(REQ_ACK, 16'd0, wr_next_seq);

    // Random phases across the register range
    run_phase(24'd1, 5'd31, 400);
    run_phase(24'd3, 5'd10, 400);
    run_phase(24'hFF_FFFF, 5'd0, 300);
    run_phase(24'd2, 5'd5, 350);
    quiet = 1'b1;
    run_phase(24'd5, 5'd31, 350);

    // Let the timer run out: timeouts 2, 3, 4, then the endpoint fails and
    // ignores everything after
    reconfigure(24'd2, 5'd2);
    issue(REQ_START_WRITE, 16'd3000, 32'd0);
    for (k = 0; k < 12; k++) issue(REQ_TICK, 16'd0, 32'd0);
    for (k = 0; k < 12; k++) rand_item(counted);

    settle();
    if (errors == 0) begin
      $display("PASS stop_and_wait_arq_endpoint");
    end else begin
      $display("FAIL stop_and_wait_arq_endpoint");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sawa_pkg.sv
sv/sawa_tx.sv
sv/sawa_rx.sv
sv/stop_and_wait_arq_endpoint.sv
bench/arq_endpoint_checker.sv
bench/tb_stop_and_wait_arq_endpoint.sv
